>>> rtl/core/fjop_pkg.sv
// Shared types, constants and helper functions for the flat JSON object parser.
// No dependencies.
package fjop_pkg;

    localparam int unsigned MaxMembersDef = 64;
    localparam int unsigned MaxKeyLenDef  = 32;
    localparam int unsigned MaxBytesRst   = 65536;
    localparam int unsigned CountW        = 25;
    localparam int unsigned OutDataW      = 24;

    localparam logic [3:0] E_NONE     = 4'd0;
    localparam logic [3:0] E_LARGE    = 4'd1;
    localparam logic [3:0] E_NOTOBJ   = 4'd2;
    localparam logic [3:0] E_KEY      = 4'd3;
    localparam logic [3:0] E_COLON    = 4'd4;
    localparam logic [3:0] E_TRUNC    = 4'd5;
    localparam logic [3:0] E_STRING   = 4'd6;
    localparam logic [3:0] E_NESTED   = 4'd7;
    localparam logic [3:0] E_LITERAL  = 4'd8;
    localparam logic [3:0] E_VALUE    = 4'd9;
    localparam logic [3:0] E_DUP      = 4'd10;
    localparam logic [3:0] E_MANY     = 4'd11;
    localparam logic [3:0] E_SEP      = 4'd12;
    localparam logic [3:0] E_TRAIL    = 4'd13;
    localparam logic [3:0] E_KEYLONG  = 4'd14;

    localparam logic [1:0] ROLE_STRUCT = 2'd0;
    localparam logic [1:0] ROLE_KEY    = 2'd1;
    localparam logic [1:0] ROLE_VALUE  = 2'd2;

    localparam logic [1:0] LIT_TRUE  = 2'd0;
    localparam logic [1:0] LIT_FALSE = 2'd1;
    localparam logic [1:0] LIT_NULL  = 2'd2;

    typedef enum logic [3:0] {
        PH_START, PH_OPEN, PH_EMPTY, PH_KEYWAIT, PH_KEY, PH_COLON,
        PH_VALWAIT, PH_VSTR, PH_LIT, PH_NUM, PH_AFTER, PH_TAIL
    } t_phase;

    typedef enum logic [2:0] {
        SC_IDLE, SC_LRD, SC_LCMP, SC_BRD, SC_BCMP
    } t_scan_state;

    typedef struct packed {
        logic done;
        logic dup;
    } t_ks_status;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return is_digit(c) || (c == 8'h2E) || (c == 8'h65) || (c == 8'h45) ||
               (c == 8'h2D) || (c == 8'h2B);
    endfunction

    function automatic logic [8:0] unescape(input logic [7:0] e);
        logic [8:0] r;
        unique case (e)
            8'h22:   r = {1'b1, 8'h22};
            8'h5C:   r = {1'b1, 8'h5C};
            8'h2F:   r = {1'b1, 8'h2F};
            8'h62:   r = {1'b1, 8'h08};
            8'h66:   r = {1'b1, 8'h0C};
            8'h6E:   r = {1'b1, 8'h0A};
            8'h72:   r = {1'b1, 8'h0D};
            8'h74:   r = {1'b1, 8'h09};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] k);
        return (k == LIT_FALSE) ? 3'd5 : 3'd4;
    endfunction

    function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] p);
        logic [39:0] s;
        unique case (k)
            LIT_TRUE:  s = {8'h00, 8'h65, 8'h75, 8'h72, 8'h74};
            LIT_FALSE: s = {8'h65, 8'h73, 8'h6C, 8'h61, 8'h66};
            default:   s = {8'h00, 8'h6C, 8'h6C, 8'h75, 8'h6E};
        endcase
        return (p < 3'd5) ? s[p*8 +: 8] : 8'h00;
    endfunction

endpackage

>>> rtl/core/fjop_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fjop_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/core/fjop_key_store.sv
// Key store and duplicate-key scanner: stored keys, key lengths, current key.
// Depends on fjop_pkg and fjop_ram.
module fjop_key_store #(
    parameter int unsigned MAX_MEMBERS = fjop_pkg::MaxMembersDef,
    parameter int unsigned MAX_KEY_LEN = fjop_pkg::MaxKeyLenDef,
    parameter int unsigned SW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1,
    parameter int unsigned PW = $clog2(MAX_KEY_LEN + 1),
    parameter int unsigned CW = $clog2(MAX_MEMBERS + 2)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_kb_we,
    input  logic [SW-1:0]         i_kb_slot,
    input  logic [PW-1:0]         i_kb_pos,
    input  logic [7:0]            i_kb_data,
    input  logic                  i_len_we,
    input  logic [SW-1:0]         i_len_slot,
    input  logic [PW-1:0]         i_len_data,
    input  logic                  i_start,
    input  logic [CW-1:0]         i_count,
    input  logic [PW-1:0]         i_klen,
    output fjop_pkg::t_ks_status  o_st
);
    localparam int unsigned Depth = MAX_MEMBERS * MAX_KEY_LEN;
    localparam int unsigned KAW   = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned JW    = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;

    fjop_pkg::t_scan_state r_state, n_state;
    logic [SW-1:0] r_i, n_i;
    logic [JW-1:0] r_j, n_j;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [PW-1:0] r_klen, n_klen;
    logic          done, dup;

    logic [PW-1:0] len_rd;
    logic [7:0]    key_rd, cur_rd;
    logic [KAW-1:0] kb_waddr, kb_raddr;
    logic [JW-1:0]  cur_waddr;
    logic           kb_slot_we;

    assign kb_waddr   = KAW'(i_kb_slot * MAX_KEY_LEN) + KAW'(i_kb_pos);
    assign kb_raddr   = KAW'(r_i * MAX_KEY_LEN) + KAW'(r_j);
    assign cur_waddr  = JW'(i_kb_pos);
    assign kb_slot_we = i_kb_we && (i_count < CW'(MAX_MEMBERS));

    fjop_ram #(.WIDTH(8), .DEPTH(Depth), .AW(KAW)) u_keys (
        .i_clk(i_clk), .i_we(kb_slot_we), .i_waddr(kb_waddr), .i_wdata(i_kb_data),
        .i_raddr(kb_raddr), .o_rdata(key_rd)
    );
    fjop_ram #(.WIDTH(8), .DEPTH(MAX_KEY_LEN), .AW(JW)) u_cur (
        .i_clk(i_clk), .i_we(i_kb_we), .i_waddr(cur_waddr), .i_wdata(i_kb_data),
        .i_raddr(r_j), .o_rdata(cur_rd)
    );
    fjop_ram #(.WIDTH(PW), .DEPTH(MAX_MEMBERS), .AW(SW)) u_lens (
        .i_clk(i_clk), .i_we(i_len_we), .i_waddr(i_len_slot), .i_wdata(i_len_data),
        .i_raddr(r_i), .o_rdata(len_rd)
    );

    logic last_i;
    assign last_i = (CW'(r_i) + CW'(1)) == r_cnt;

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_cnt   = r_cnt;
        n_klen  = r_klen;
        unique case (r_state)
            fjop_pkg::SC_IDLE: begin
                if (i_start && (i_count != '0)) begin
                    n_state = fjop_pkg::SC_LRD;
                    n_i     = '0;
                    n_cnt   = i_count;
                    n_klen  = i_klen;
                end
            end
            fjop_pkg::SC_LRD: n_state = fjop_pkg::SC_LCMP;
            fjop_pkg::SC_LCMP: begin
                if (len_rd == r_klen) begin
                    if (r_klen == '0) begin
                        n_state = fjop_pkg::SC_IDLE;
                    end else begin
                        n_j     = '0;
                        n_state = fjop_pkg::SC_BRD;
                    end
                end else if (last_i) begin
                    n_state = fjop_pkg::SC_IDLE;
                end else begin
                    n_i     = r_i + SW'(1);
                    n_state = fjop_pkg::SC_LRD;
                end
            end
            fjop_pkg::SC_BRD: n_state = fjop_pkg::SC_BCMP;
            fjop_pkg::SC_BCMP: begin
                if (key_rd == cur_rd) begin
                    if ((PW'(r_j) + PW'(1)) == r_klen) begin
                        n_state = fjop_pkg::SC_IDLE;
                    end else begin
                        n_j     = r_j + JW'(1);
                        n_state = fjop_pkg::SC_BRD;
                    end
                end else if (last_i) begin
                    n_state = fjop_pkg::SC_IDLE;
                end else begin
                    n_i     = r_i + SW'(1);
                    n_state = fjop_pkg::SC_LRD;
                end
            end
            default: n_state = fjop_pkg::SC_IDLE;
        endcase
    end

    always_comb begin
        done = 1'b0;
        dup  = 1'b0;
        unique case (r_state)
            fjop_pkg::SC_IDLE: done = i_start && (i_count == '0);
            fjop_pkg::SC_LCMP: begin
                dup  = (len_rd == r_klen) && (r_klen == '0);
                done = dup || ((len_rd != r_klen) && last_i);
            end
            fjop_pkg::SC_BCMP: begin
                dup  = (key_rd == cur_rd) && ((PW'(r_j) + PW'(1)) == r_klen);
                done = dup || ((key_rd != cur_rd) && last_i);
            end
            default: done = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fjop_pkg::SC_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_i    <= n_i;
        r_j    <= n_j;
        r_cnt  <= n_cnt;
        r_klen <= n_klen;
    end

    assign o_st.done = done;
    assign o_st.dup  = dup;

    a_dup_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_st.dup |-> o_st.done) else $error("dup flagged without scan end");
    a_no_write_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != fjop_pkg::SC_IDLE) |-> !i_kb_we && !i_len_we)
        else $error("key store written during scan");
endmodule

>>> rtl/core/flat_json_object_parser_unit.sv
// Top level of the flat JSON object parser: byte parser, result register.
// Depends on fjop_pkg and fjop_key_store.
//
// Each transfer on the slave side yields one result transfer. The slave side stalls
// while a result waits unaccepted on the master side, and after a closing key
// quote: after its result the block scans the stored keys through the key store's
// registered read ports, with a read state and a compare state per length check and
// per compared byte. The end of text marker gives the verdict and re-arms the block.
module flat_json_object_parser_unit #(
    parameter int unsigned MAX_MEMBERS = fjop_pkg::MaxMembersDef,
    parameter int unsigned MAX_KEY_LEN = fjop_pkg::MaxKeyLenDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [23:0] i_cfg_data,     // max_bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // text_byte
    input  logic        s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // decoded_byte, member_index, member_done,
                                        // accepted, error_code, zero pad
    output logic [2:0]  m_axis_tuser    // role, done_res
);
    localparam int unsigned SW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
    localparam int unsigned PW = $clog2(MAX_KEY_LEN + 1);
    localparam int unsigned CW = $clog2(MAX_MEMBERS + 2);
    localparam int unsigned CntW = fjop_pkg::CountW;

    logic [23:0]     r_max;
    fjop_pkg::t_phase r_ph, n_ph;
    logic            r_esc, n_esc;
    logic [1:0]      r_lk, n_lk;
    logic [2:0]      r_lp, n_lp;
    logic            r_nd, n_nd;
    logic            r_dup, n_dup;
    logic [CntW-1:0] r_bc, n_bc;
    logic [CW-1:0]   r_mc, n_mc;
    logic [PW-1:0]   r_kp, n_kp;
    logic [3:0]      r_err, n_err;
    logic            r_scan;

    logic            r_ovalid;
    logic [23:0]     r_odata;
    logic [2:0]      r_ouser;

    logic [1:0] role;
    logic [7:0] dec;
    logic       mdone;
    logic       acc;
    logic [CW-1:0] idx;
    logic       kb_we, len_we, scan_go;
    logic [7:0] kb_data;
    fjop_pkg::t_ks_status st;
    logic       accept;

    logic [7:0] c;
    assign c = s_axis_tdata;
    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_scan && (!r_ovalid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        logic [8:0]    ue;
        logic [3:0]    fm_err;
        logic          in_key;
        logic [3:0]    ecode;
        logic [CW-1:0] cap;
        logic          content;
        logic [7:0]    cval;
        ue      = fjop_pkg::unescape(c);
        cap     = CW'(MAX_MEMBERS);
        in_key  = (r_ph == fjop_pkg::PH_KEY);
        ecode   = in_key ? fjop_pkg::E_KEY : fjop_pkg::E_STRING;
        fm_err  = r_dup ? fjop_pkg::E_DUP :
                  ((r_mc + CW'(1)) > cap) ? fjop_pkg::E_MANY : fjop_pkg::E_NONE;
        content = 1'b0;
        cval    = c;
        n_ph  = r_ph;  n_esc = r_esc; n_lk = r_lk; n_lp = r_lp; n_nd = r_nd;
        n_dup = r_dup; n_bc = r_bc;   n_mc = r_mc; n_kp = r_kp; n_err = r_err;
        role  = fjop_pkg::ROLE_STRUCT;
        dec   = 8'h00;
        mdone = 1'b0;
        acc   = 1'b0;
        kb_we = 1'b0;
        len_we = 1'b0;
        scan_go = 1'b0;
        kb_data = c;
        idx   = (r_mc > cap) ? cap : r_mc;
        if (!s_axis_tuser) begin
            if (r_bc != {CntW{1'b1}}) n_bc = r_bc + CntW'(1);
            if (n_bc > CntW'(r_max)) begin
                n_err = fjop_pkg::E_LARGE;
            end else if (r_err == fjop_pkg::E_NONE) begin
                unique case (r_ph)
                    fjop_pkg::PH_START: begin
                        if (!fjop_pkg::is_ws(c)) begin
                            if (c == 8'h7B) n_ph = fjop_pkg::PH_OPEN;
                            else n_err = fjop_pkg::E_NOTOBJ;
                        end
                    end
                    fjop_pkg::PH_OPEN, fjop_pkg::PH_KEYWAIT: begin
                        if (!fjop_pkg::is_ws(c)) begin
                            if (c == 8'h7D && r_ph == fjop_pkg::PH_OPEN) begin
                                n_ph = fjop_pkg::PH_EMPTY;
                            end else if (c == 8'h22) begin
                                n_ph = fjop_pkg::PH_KEY; n_esc = 1'b0;
                                n_kp = '0; n_dup = 1'b0;
                            end else begin
                                n_err = fjop_pkg::E_KEY;
                            end
                        end
                    end
                    fjop_pkg::PH_EMPTY, fjop_pkg::PH_TAIL: begin
                        if (!fjop_pkg::is_ws(c)) n_err = fjop_pkg::E_TRAIL;
                    end
                    fjop_pkg::PH_KEY, fjop_pkg::PH_VSTR: begin
                        if (r_esc) begin
                            n_esc = 1'b0;
                            if (!ue[8]) n_err = ecode;
                            else begin content = 1'b1; cval = ue[7:0]; end
                        end else if (c == 8'h5C) begin
                            n_esc = 1'b1;
                        end else if (c == 8'h22) begin
                            if (in_key) begin
                                scan_go = 1'b1;
                                n_dup   = 1'b0;
                                n_ph    = fjop_pkg::PH_COLON;
                            end else begin
                                mdone = 1'b1;
                                n_err = fm_err;
                                if (!r_dup) n_mc = r_mc + CW'(1);
                                len_we = (fm_err == fjop_pkg::E_NONE);
                                n_ph  = fjop_pkg::PH_AFTER;
                            end
                        end else if (c < 8'h20) begin
                            n_err = ecode;
                        end else begin
                            content = 1'b1;
                        end
                        if (content) begin
                            dec = cval;
                            if (in_key) begin
                                if (r_kp >= PW'(MAX_KEY_LEN)) begin
                                    n_err = fjop_pkg::E_KEYLONG;
                                end else begin
                                    kb_we   = 1'b1;
                                    kb_data = cval;
                                    n_kp    = r_kp + PW'(1);
                                    role    = fjop_pkg::ROLE_KEY;
                                end
                            end else begin
                                role = fjop_pkg::ROLE_VALUE;
                            end
                        end
                    end
                    fjop_pkg::PH_COLON: begin
                        if (!fjop_pkg::is_ws(c)) begin
                            if (c == 8'h3A) n_ph = fjop_pkg::PH_VALWAIT;
                            else n_err = fjop_pkg::E_COLON;
                        end
                    end
                    fjop_pkg::PH_VALWAIT: begin
                        if (!fjop_pkg::is_ws(c)) begin
                            if (c == 8'h22) begin
                                n_ph = fjop_pkg::PH_VSTR; n_esc = 1'b0;
                            end else if (c == 8'h7B || c == 8'h5B) begin
                                n_err = fjop_pkg::E_NESTED;
                            end else if (c == 8'h74 || c == 8'h66 || c == 8'h6E) begin
                                n_lk = (c == 8'h74) ? fjop_pkg::LIT_TRUE :
                                       (c == 8'h66) ? fjop_pkg::LIT_FALSE :
                                                      fjop_pkg::LIT_NULL;
                                n_lp = 3'd1;
                                n_ph = fjop_pkg::PH_LIT;
                                if (n_lk != fjop_pkg::LIT_NULL) begin
                                    role = fjop_pkg::ROLE_VALUE; dec = c;
                                end
                            end else if (fjop_pkg::is_num(c)) begin
                                n_nd = fjop_pkg::is_digit(c);
                                n_ph = fjop_pkg::PH_NUM;
                                role = fjop_pkg::ROLE_VALUE; dec = c;
                            end else begin
                                n_err = fjop_pkg::E_VALUE;
                            end
                        end
                    end
                    fjop_pkg::PH_LIT: begin
                        if (r_lp < fjop_pkg::lit_len(r_lk) &&
                            c == fjop_pkg::lit_char(r_lk, r_lp)) begin
                            if (r_lk != fjop_pkg::LIT_NULL) begin
                                role = fjop_pkg::ROLE_VALUE; dec = c;
                            end
                            n_lp = r_lp + 3'd1;
                            if (n_lp >= fjop_pkg::lit_len(r_lk)) begin
                                mdone = 1'b1;
                                n_err = fm_err;
                                if (!r_dup) n_mc = r_mc + CW'(1);
                                len_we = (fm_err == fjop_pkg::E_NONE);
                                n_ph  = fjop_pkg::PH_AFTER;
                            end
                        end else begin
                            n_err = fjop_pkg::E_LITERAL;
                        end
                    end
                    fjop_pkg::PH_NUM: begin
                        if (fjop_pkg::is_num(c)) begin
                            if (fjop_pkg::is_digit(c)) n_nd = 1'b1;
                            role = fjop_pkg::ROLE_VALUE; dec = c;
                        end else if (!r_nd) begin
                            n_err = fjop_pkg::E_VALUE;
                        end else begin
                            mdone = 1'b1;
                            n_err = fm_err;
                            if (!r_dup) n_mc = r_mc + CW'(1);
                            len_we = (fm_err == fjop_pkg::E_NONE);
                            n_ph  = fjop_pkg::PH_AFTER;
                            if (fm_err == fjop_pkg::E_NONE && !fjop_pkg::is_ws(c)) begin
                                if (c == 8'h2C) n_ph = fjop_pkg::PH_KEYWAIT;
                                else if (c == 8'h7D) n_ph = fjop_pkg::PH_TAIL;
                                else n_err = fjop_pkg::E_SEP;
                            end
                        end
                    end
                    fjop_pkg::PH_AFTER: begin
                        if (!fjop_pkg::is_ws(c)) begin
                            if (c == 8'h2C) n_ph = fjop_pkg::PH_KEYWAIT;
                            else if (c == 8'h7D) n_ph = fjop_pkg::PH_TAIL;
                            else n_err = fjop_pkg::E_SEP;
                        end
                    end
                    default: n_err = fjop_pkg::E_NOTOBJ;
                endcase
            end
            if (n_err != fjop_pkg::E_NONE) begin
                role = fjop_pkg::ROLE_STRUCT; dec = 8'h00; mdone = 1'b0;
                kb_we = 1'b0; len_we = 1'b0; scan_go = 1'b0;
            end
        end else begin
            if (r_err == fjop_pkg::E_NONE) begin
                unique case (r_ph)
                    fjop_pkg::PH_EMPTY, fjop_pkg::PH_TAIL: n_err = fjop_pkg::E_NONE;
                    fjop_pkg::PH_START:   n_err = fjop_pkg::E_NOTOBJ;
                    fjop_pkg::PH_OPEN, fjop_pkg::PH_KEYWAIT,
                    fjop_pkg::PH_KEY:     n_err = fjop_pkg::E_KEY;
                    fjop_pkg::PH_COLON:   n_err = fjop_pkg::E_COLON;
                    fjop_pkg::PH_VALWAIT: n_err = fjop_pkg::E_TRUNC;
                    fjop_pkg::PH_VSTR:    n_err = fjop_pkg::E_STRING;
                    fjop_pkg::PH_LIT:     n_err = fjop_pkg::E_LITERAL;
                    fjop_pkg::PH_NUM: begin
                        if (!r_nd) begin
                            n_err = fjop_pkg::E_VALUE;
                        end else begin
                            if (!r_dup) n_mc = r_mc + CW'(1);
                            n_err = (fm_err != fjop_pkg::E_NONE) ? fm_err : fjop_pkg::E_SEP;
                        end
                    end
                    default: n_err = fjop_pkg::E_SEP;
                endcase
            end
            if (r_bc > CntW'(r_max)) n_err = fjop_pkg::E_LARGE;
            acc = (n_err == fjop_pkg::E_NONE);
            idx = (n_mc > cap) ? cap : n_mc;
        end
    end

    fjop_key_store #(
        .MAX_MEMBERS(MAX_MEMBERS), .MAX_KEY_LEN(MAX_KEY_LEN),
        .SW(SW), .PW(PW), .CW(CW)
    ) u_keys (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_kb_we(accept && kb_we),
        .i_kb_slot(SW'(r_mc)), .i_kb_pos(r_kp), .i_kb_data(kb_data),
        .i_len_we(accept && len_we), .i_len_slot(SW'(r_mc)), .i_len_data(r_kp),
        .i_start(accept && scan_go),
        .i_count((r_mc > CW'(MAX_MEMBERS)) ? CW'(MAX_MEMBERS) : r_mc),
        .i_klen(r_kp), .o_st(st)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max    <= 24'(fjop_pkg::MaxBytesRst);
            r_ph     <= fjop_pkg::PH_START;
            r_esc    <= 1'b0;
            r_lk     <= 2'd0;
            r_lp     <= 3'd0;
            r_nd     <= 1'b0;
            r_dup    <= 1'b0;
            r_bc     <= '0;
            r_mc     <= '0;
            r_kp     <= '0;
            r_err    <= fjop_pkg::E_NONE;
            r_scan   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_max <= i_cfg_data;
            if (accept) begin
                r_ovalid <= 1'b1;
                if (s_axis_tuser) begin
                    r_ph  <= fjop_pkg::PH_START;
                    r_esc <= 1'b0; r_lk <= 2'd0; r_lp <= 3'd0; r_nd <= 1'b0;
                    r_dup <= 1'b0; r_bc <= '0; r_mc <= '0; r_kp <= '0;
                    r_err <= fjop_pkg::E_NONE;
                end else begin
                    r_ph  <= n_ph;  r_esc <= n_esc; r_lk <= n_lk; r_lp <= n_lp;
                    r_nd  <= n_nd;  r_dup <= n_dup; r_bc <= n_bc; r_mc <= n_mc;
                    r_kp  <= n_kp;  r_err <= n_err;
                    r_scan <= scan_go && !st.done;
                end
            end else begin
                if (m_axis_tready) r_ovalid <= 1'b0;
                if (st.done) begin
                    r_scan <= 1'b0;
                    r_dup  <= st.dup;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_odata <= {3'b000, n_err, acc, mdone, 7'(idx), dec};
            r_ouser <= {s_axis_tuser, role};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    a_stall_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan |-> !s_axis_tready) else $error("input taken during key scan");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st.done |-> (r_scan || accept)) else $error("scan end without request");
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !s_axis_tuser && r_err != fjop_pkg::E_NONE) |=>
        (r_err != fjop_pkg::E_NONE)) else $error("sticky error lost");
endmodule

>>> verif/tb_flat_json_object_parser_unit.sv
// Testbench for flat_json_object_parser_unit: feeds JSON texts byte by byte,
// predicts every result transfer with a scoreboard class and checks each field.
// Depends on fjop_pkg and the parser RTL.
module tb_flat_json_object_parser_unit;
    import fjop_pkg::*;

    localparam int KeyMax  = 32;
    localparam int MemMax  = 64;
    localparam int WdLimit = 60000;
    localparam int ScanWait = 4600;

    typedef struct {
        logic [1:0] role;
        logic [7:0] dec;
        logic [6:0] idx;
        logic       mdone;
        logic       done;
        logic       acc;
        logic [3:0] code;
    } parse_result_t;

    class json_scoreboard;
        logic [23:0] max_bytes;
        t_phase      phase;
        bit          esc;
        logic [1:0]  lkind;
        int          lpos;
        bit          num_digit;
        bit          dup;
        logic [24:0] bcount;
        int          mcount;
        int          kpos;
        logic [3:0]  err;
        byte unsigned keys [MemMax][KeyMax];
        int          klen [MemMax];
        byte unsigned cur [KeyMax];
        parse_result_t pending [$];
        int          fails;
        int          verdicts;
        int          accepted_texts;
        bit [15:0]   codes_seen;

        function new();
            max_bytes = 24'(MaxBytesRst);
            fails = 0;
            verdicts = 0;
            accepted_texts = 0;
            codes_seen = '0;
            clear_text();
        endfunction

        function void clear_text();
            phase = PH_START;
            esc = 0; lkind = LIT_TRUE; lpos = 0; num_digit = 0; dup = 0;
            bcount = '0; mcount = 0; kpos = 0; err = E_NONE;
            foreach (klen[i]) klen[i] = 0;
        endfunction

        function void set_err(logic [3:0] e);
            if (err == E_NONE) err = e;
        endfunction

        function bit ws(byte unsigned c);
            return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
        endfunction

        function bit digit(byte unsigned c);
            return c >= "0" && c <= "9";
        endfunction

        function bit numch(byte unsigned c);
            return digit(c) || c == "." || c == "e" || c == "E" || c == "-" || c == "+";
        endfunction

        function void close_key();
            int j;
            dup = 0;
            for (int i = 0; i < mcount && i < MemMax; i++) begin
                if (klen[i] != kpos) continue;
                for (j = 0; j < kpos; j++)
                    if (keys[i][j] != cur[j]) break;
                if (j >= kpos) begin
                    dup = 1;
                    return;
                end
            end
        endfunction

        function void finish_member();
            if (dup) begin
                set_err(E_DUP);
                return;
            end
            mcount++;
            if (mcount > MemMax) begin
                set_err(E_MANY);
                return;
            end
            for (int j = 0; j < KeyMax; j++) keys[mcount-1][j] = cur[j];
            klen[mcount-1] = kpos;
        endfunction

        function void after_value(byte unsigned c);
            if (ws(c)) return;
            if (c == ",") phase = PH_KEYWAIT;
            else if (c == "}") phase = PH_TAIL;
            else set_err(E_SEP);
        endfunction

        function void start_key();
            phase = PH_KEY; esc = 0; kpos = 0; dup = 0;
        endfunction

        function void put_content(bit in_key, byte unsigned d, ref parse_result_t r);
            if (in_key) begin
                if (kpos >= KeyMax) begin
                    set_err(E_KEYLONG);
                    return;
                end
                cur[kpos] = d;
                kpos++;
                r.role = ROLE_KEY;
            end else begin
                r.role = ROLE_VALUE;
            end
            r.dec = d;
        endfunction

        function bit resolve(byte unsigned e, output byte unsigned d);
            case (e)
                "\"": d = 8'h22;
                "\\": d = 8'h5C;
                "/":  d = 8'h2F;
                "b":  d = 8'h08;
                "f":  d = 8'h0C;
                "n":  d = 8'h0A;
                "r":  d = 8'h0D;
                "t":  d = 8'h09;
                default: return 0;
            endcase
            return 1;
        endfunction

        function void take_byte(byte unsigned c, ref parse_result_t r);
            bit in_key;
            logic [3:0] ecode;
            byte unsigned d;
            string lit;
            in_key = (phase == PH_KEY);
            ecode = in_key ? E_KEY : E_STRING;
            case (phase)
                PH_START: if (!ws(c)) begin
                    if (c == "{") phase = PH_OPEN; else set_err(E_NOTOBJ);
                end
                PH_OPEN: if (!ws(c)) begin
                    if (c == "}") phase = PH_EMPTY;
                    else if (c == "\"") start_key();
                    else set_err(E_KEY);
                end
                PH_EMPTY, PH_TAIL: if (!ws(c)) set_err(E_TRAIL);
                PH_KEYWAIT: if (!ws(c)) begin
                    if (c == "\"") start_key(); else set_err(E_KEY);
                end
                PH_KEY, PH_VSTR: begin
                    if (esc) begin
                        esc = 0;
                        if (!resolve(c, d)) set_err(ecode);
                        else put_content(in_key, d, r);
                    end else if (c == "\\") begin
                        esc = 1;
                    end else if (c == "\"") begin
                        if (in_key) begin
                            close_key();
                            phase = PH_COLON;
                        end else begin
                            r.mdone = 1;
                            finish_member();
                            phase = PH_AFTER;
                        end
                    end else if (c < 8'h20) begin
                        set_err(ecode);
                    end else begin
                        put_content(in_key, c, r);
                    end
                end
                PH_COLON: if (!ws(c)) begin
                    if (c == ":") phase = PH_VALWAIT; else set_err(E_COLON);
                end
                PH_VALWAIT: if (!ws(c)) begin
                    if (c == "\"") begin
                        phase = PH_VSTR;
                        esc = 0;
                    end else if (c == "{" || c == "[") begin
                        set_err(E_NESTED);
                    end else if (c == "t" || c == "f" || c == "n") begin
                        lkind = (c == "t") ? LIT_TRUE : (c == "f") ? LIT_FALSE : LIT_NULL;
                        lpos = 1;
                        phase = PH_LIT;
                        if (lkind != LIT_NULL) begin
                            r.role = ROLE_VALUE;
                            r.dec = c;
                        end
                    end else if (numch(c)) begin
                        num_digit = digit(c);
                        phase = PH_NUM;
                        r.role = ROLE_VALUE;
                        r.dec = c;
                    end else begin
                        set_err(E_VALUE);
                    end
                end
                PH_LIT: begin
                    if (lkind == LIT_TRUE) lit = "true";
                    else if (lkind == LIT_FALSE) lit = "false";
                    else lit = "null";
                    if (lpos < lit.len() && c == lit[lpos]) begin
                        if (lkind != LIT_NULL) begin
                            r.role = ROLE_VALUE;
                            r.dec = c;
                        end
                        lpos++;
                        if (lpos >= lit.len()) begin
                            r.mdone = 1;
                            finish_member();
                            phase = PH_AFTER;
                        end
                    end else begin
                        set_err(E_LITERAL);
                    end
                end
                PH_NUM: begin
                    if (numch(c)) begin
                        if (digit(c)) num_digit = 1;
                        r.role = ROLE_VALUE;
                        r.dec = c;
                    end else if (!num_digit) begin
                        set_err(E_VALUE);
                    end else begin
                        r.mdone = 1;
                        finish_member();
                        phase = PH_AFTER;
                        if (err == E_NONE) after_value(c);
                    end
                end
                PH_AFTER: after_value(c);
                default: set_err(E_NOTOBJ);
            endcase
        endfunction

        function void note_input(bit action, byte unsigned c);
            parse_result_t r;
            r = '{ROLE_STRUCT, 8'h00, 7'(mcount > MemMax ? MemMax : mcount), 0, action, 0, 0};
            if (!action) begin
                if (bcount != 25'h1FFFFFF) bcount++;
                if (bcount > max_bytes) err = E_LARGE;
                if (err == E_NONE) take_byte(c, r);
                if (err != E_NONE) begin
                    r.role = ROLE_STRUCT;
                    r.dec = 0;
                    r.mdone = 0;
                end
                r.code = err;
            end else begin
                if (err == E_NONE) begin
                    case (phase)
                        PH_EMPTY, PH_TAIL: ;
                        PH_START: set_err(E_NOTOBJ);
                        PH_OPEN, PH_KEYWAIT, PH_KEY: set_err(E_KEY);
                        PH_COLON: set_err(E_COLON);
                        PH_VALWAIT: set_err(E_TRUNC);
                        PH_VSTR: set_err(E_STRING);
                        PH_LIT: set_err(E_LITERAL);
                        PH_NUM: begin
                            if (!num_digit) set_err(E_VALUE);
                            else begin
                                finish_member();
                                set_err(E_SEP);
                            end
                        end
                        default: set_err(E_SEP);
                    endcase
                end
                if (bcount > max_bytes) err = E_LARGE;
                r.code = err;
                r.acc = (err == E_NONE);
                r.idx = 7'(mcount > MemMax ? MemMax : mcount);
                verdicts++;
                accepted_texts += r.acc;
                codes_seen[err] = 1;
                clear_text();
            end
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(logic [23:0] data, logic [2:0] user);
            parse_result_t e;
            if (pending.size() == 0) begin
                $error("unexpected result transfer tdata=%h tuser=%h", data, user);
                fails++;
                return;
            end
            e = pending.pop_front();
            if (user[1:0] !== e.role) begin
                $error("role: expected %0d, got %0d", e.role, user[1:0]); fails++;
            end
            if (user[2] !== e.done) begin
                $error("done_res: expected %0d, got %0d", e.done, user[2]); fails++;
            end
            if (data[7:0] !== e.dec) begin
                $error("decoded_byte: expected %h, got %h", e.dec, data[7:0]); fails++;
            end
            if (data[14:8] !== e.idx) begin
                $error("member_index: expected %0d, got %0d", e.idx, data[14:8]); fails++;
            end
            if (data[15] !== e.mdone) begin
                $error("member_done: expected %0d, got %0d", e.mdone, data[15]); fails++;
            end
            if (data[16] !== e.acc) begin
                $error("accepted: expected %0d, got %0d", e.acc, data[16]); fails++;
            end
            if (data[20:17] !== e.code) begin
                $error("error_code: expected %0d, got %0d", e.code, data[20:17]); fails++;
            end
            if (data[23:21] !== 3'b000) begin
                $error("pad: expected 0, got %0d", data[23:21]); fails++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [23:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    flat_json_object_parser_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    json_scoreboard sb = new();
    int bytes_sent;
    int texts_sent;
    int burst_left;
    int idle_cycles;
    int rx_cycle;
    int rx_mode;

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 200 == 0) rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= $urandom_range(0, 1);
            2: m_axis_tready <= ($urandom_range(0, 7) == 0);
            default: m_axis_tready <= ((rx_cycle % 16) < 11);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    always @(posedge i_clk) begin
        if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WdLimit) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_item(bit action, byte unsigned c);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= action;
        s_axis_tdata  <= c;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_input(action, c);
        if (!action) bytes_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120) : $urandom_range(0, 12);
            gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_text(byte unsigned t[$]);
        foreach (t[i]) send_item(0, t[i]);
        send_item(1, 8'($urandom_range(0, 255)));
        texts_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (ScanWait) @(posedge i_clk);
    endtask

    task automatic write_max_bytes(logic [23:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.max_bytes = v;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void append_byte(ref byte unsigned q[$], input byte unsigned b);
        q.insert(q.size(), b);
    endfunction

    function automatic void push_str(ref byte unsigned q[$], input string s);
        for (int i = 0; i < s.len(); i++) append_byte(q, s[i]);
    endfunction

    function automatic void push_ws(ref byte unsigned q[$]);
        string w = " \t\r\n";
        if ($urandom_range(0, 3) == 0) append_byte(q, w[$urandom_range(0, 3)]);
    endfunction

    function automatic void push_content(ref byte unsigned q[$], input int n);
        string e = "\"\\/bfnrt";
        byte unsigned c;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 19))
                0: begin append_byte(q, "\\"); append_byte(q, e[$urandom_range(0, 7)]); end
                1: if ($urandom_range(0, 3) == 0) begin
                    append_byte(q, "\\"); append_byte(q, 8'($urandom_range(0, 255)));
                end
                2: if ($urandom_range(0, 5) == 0) append_byte(q, 8'($urandom_range(0, 31)));
                default: begin
                    c = 8'($urandom_range(8'h20, 8'hFF));
                    if (c == "\"" || c == "\\") c = "a";
                    append_byte(q, c);
                end
            endcase
        end
    endfunction

    function automatic void build_text(ref byte unsigned q[$], input int forced_members);
        int n;
        string nums = "0123456789.eE+-";
        q.delete();
        if ($urandom_range(0, 19) == 0) begin
            n = $urandom_range(1, 12);
            repeat (n) append_byte(q, 8'($urandom_range(0, 255)));
            return;
        end
        n = forced_members > 0 ? forced_members : $urandom_range(0, 5);
        push_ws(q);
        append_byte(q, "{");
        for (int m = 0; m < n; m++) begin
            if (m > 0) append_byte(q, ",");
            push_ws(q);
            append_byte(q, "\"");
            if (forced_members > 0) begin
                append_byte(q, 8'(8'h41 + m % 26)); append_byte(q, 8'(8'h41 + m / 26));
            end else if ($urandom_range(0, 19) == 0) begin
                push_content(q, $urandom_range(31, 34));
            end else if ($urandom_range(0, 9) == 0) begin
                push_content(q, $urandom_range(0, 3));
            end else begin
                repeat ($urandom_range(0, 2)) append_byte(q, $urandom_range(0, 1) ? "a" : "b");
            end
            append_byte(q, "\"");
            push_ws(q);
            append_byte(q, ":");
            push_ws(q);
            if (forced_members > 0) begin
                append_byte(q, 8'(8'h30 + m % 10));
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2: begin
                        append_byte(q, "\"");
                        push_content(q, $urandom_range(0, 5));
                        append_byte(q, "\"");
                    end
                    3: push_str(q, "true");
                    4: push_str(q, "false");
                    5: push_str(q, "null");
                    6, 7: repeat ($urandom_range(1, 5)) append_byte(q, nums[$urandom_range(0, 14)]);
                    8: push_str(q, $urandom_range(0, 1) ? "tru" : "nul1");
                    default: append_byte(q, $urandom_range(0, 1) ? "{" : "[");
                endcase
            end
            push_ws(q);
        end
        append_byte(q, "}");
        push_ws(q);
        if ($urandom_range(0, 9) == 0) append_byte(q, 8'($urandom_range(0, 255)));
        if (forced_members == 0 && $urandom_range(0, 9) == 0 && q.size() > 1)
            q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
        if (forced_members == 0 && $urandom_range(0, 14) == 0)
            q = q[0:$urandom_range(0, q.size() - 1)];
    endfunction

    task automatic send_string(string s);
        byte unsigned q[$];
        push_str(q, s);
        send_text(q);
    endtask

    initial begin
        logic [23:0] settings [5];
        byte unsigned q[$];
        int phase_start;
        settings = '{24'd65536, 24'd0, 24'hFFFFFF, 24'd40, 24'd0};
        settings[4] = 24'($urandom_range(20, 400));
        bytes_sent = 0; texts_sent = 0; burst_left = 0;
        i_rst_n <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_string("{}");
        send_string("{\"a\":true,\"b\":false,\"c\":null,\"d\":-1.5e+3}");
        send_string("{\"k\\n\\\"\":\"\\\\\\t\\b\\f\\r\\/\",\"k\\n\\\"\":7}");
        drain();
        send_string("{} x");
        send_string("{\"a\":\"\\u\"}");

        for (int p = 0; p < 5; p++) begin
            write_max_bytes(settings[p]);
            phase_start = bytes_sent;
            if (p == 2) begin
                build_text(q, MemMax + 1);
                send_text(q);
            end
            while (bytes_sent - phase_start < 20) begin
                build_text(q, 0);
                send_text(q);
                if (texts_sent % 37 == 0) drain();
            end
        end

        drain();
        $display("Sent %0d texts, %0d bytes; %0d verdicts, %0d accepted.",
                 texts_sent, bytes_sent, sb.verdicts, sb.accepted_texts);
        $display("Error codes reached (bit mask): %b", sb.codes_seen);
        if (sb.fails == 0 && sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

>>> sim.f
rtl/core/fjop_pkg.sv
rtl/core/fjop_ram.sv
rtl/core/fjop_key_store.sv
rtl/core/flat_json_object_parser_unit.sv
verif/tb_flat_json_object_parser_unit.sv
